// ===== hdl/trcs_pkg.sv =====
// shared types and constants for the tile map rectangle collision scan unit
package trcs_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_NUM_LAYERS  = 4;

  localparam int COORD_W = 26;
  localparam int DIM_W   = 11;
  localparam int TS_W    = 13;
  localparam int SCAN_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_COLUMNS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_PRESENT = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
    logic [TS_W-1:0]   tsq;
    logic [SCAN_W-1:0] scan;
  } cfg_t;

  typedef struct packed {
    logic                      query;
    logic                      reject;
    logic [1:0]                layer;
    logic [5:0]                wrow;
    logic [5:0]                wcol;
    logic                      wsolid;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] bottom;
    logic [DIM_W-1:0]          cmin;
    logic signed [COORD_W-1:0] tx0;
  } item_t;

endpackage

// ===== hdl/trcs_front.sv =====
// front part: accepts items, checks rejection and finds the start column
module trcs_front #(
  parameter int MAX_COLUMNS = trcs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = trcs_pkg::DEF_MAX_ROWS,
  parameter int NUM_LAYERS  = trcs_pkg::DEF_NUM_LAYERS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                operation,
  input  logic [1:0]          layer,
  input  logic [5:0]          tile_row,
  input  logic [5:0]          tile_column,
  input  logic                tile_solid,
  input  logic signed [15:0]  rect_left,
  input  logic signed [15:0]  rect_top,
  input  logic [14:0]         rect_width,
  input  logic [14:0]         rect_height,
  input  trcs_pkg::cfg_t      cfg,
  input  logic [3:0]          layer_present,
  output logic                busy,
  output logic                push,
  input  logic                q_full,
  output trcs_pkg::item_t     ent
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_CHECK, F_DIV, F_TX, F_PUSH} fstate_t;

  fstate_t state;
  logic signed [trcs_pkg::COORD_W-1:0] cols_t;
  logic signed [trcs_pkg::COORD_W-1:0] rows_t;
  logic [14:0] dq;
  logic [trcs_pkg::TS_W-1:0] rem;
  logic [3:0] cnt;
  logic [trcs_pkg::TS_W:0] sh;
  logic [trcs_pkg::TS_W:0] sh_sub;
  logic reject_q;

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !q_full;

  assign sh     = {rem, dq[14]};
  assign sh_sub = sh - (trcs_pkg::TS_W+1)'(cfg.tsq);

  always_comb begin
    reject_q = (32'(ent.layer) >= 32'(NUM_LAYERS)) || !layer_present[ent.layer] ||
               (ent.right < 0) || (ent.left > cols_t) ||
               (ent.bottom < 0) || (ent.top > rows_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (take) begin
            ent.query  <= operation;
            ent.layer  <= layer;
            ent.wrow   <= tile_row;
            ent.wcol   <= tile_column;
            ent.wsolid <= tile_solid;
            ent.left   <= trcs_pkg::COORD_W'(rect_left);
            ent.top    <= trcs_pkg::COORD_W'(rect_top);
            ent.right  <= trcs_pkg::COORD_W'(rect_left) +
                          $signed(trcs_pkg::COORD_W'(rect_width));
            ent.bottom <= trcs_pkg::COORD_W'(rect_top) +
                          $signed(trcs_pkg::COORD_W'(rect_height));
            ent.cmin   <= '0;
            ent.tx0    <= '0;
            ent.reject <= !((32'(layer) < 32'(NUM_LAYERS)) &&
                            (32'(tile_row) < 32'(MAX_ROWS)) &&
                            (32'(tile_column) < 32'(MAX_COLUMNS)));
            state <= operation ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          cols_t <= $signed(trcs_pkg::COORD_W'(cfg.cols * cfg.tsq));
          rows_t <= $signed(trcs_pkg::COORD_W'(cfg.rows * cfg.tsq));
          state  <= F_CHECK;
        end
        F_CHECK: begin
          ent.reject <= reject_q;
          dq  <= ent.left[14:0];
          rem <= '0;
          cnt <= '0;
          if (!reject_q && ent.left > 0) begin
            state <= F_DIV;
          end else begin
            state <= F_PUSH;
          end
        end
        F_DIV: begin
          if (!sh_sub[trcs_pkg::TS_W]) begin
            rem <= sh_sub[trcs_pkg::TS_W-1:0];
            dq  <= {dq[13:0], 1'b1};
          end else begin
            rem <= sh[trcs_pkg::TS_W-1:0];
            dq  <= {dq[13:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd14) begin
            state <= F_TX;
          end
        end
        F_TX: begin
          if ({1'b0, dq} > 16'(cfg.cols)) begin
            ent.cmin <= cfg.cols;
            ent.tx0  <= $signed(trcs_pkg::COORD_W'(cfg.cols * cfg.tsq));
          end else begin
            ent.cmin <= trcs_pkg::DIM_W'(dq);
            ent.tx0  <= $signed(trcs_pkg::COORD_W'(trcs_pkg::DIM_W'(dq) * cfg.tsq));
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/trcs_queue.sv =====
// two-entry queue between front and back
module trcs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  trcs_pkg::item_t din,
  input  logic            pop,
  output trcs_pkg::item_t dout,
  output logic            full,
  output logic            empty
);

  trcs_pkg::item_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/trcs_back.sv =====
// back part: tile memory, row and column scan, result register
module trcs_back #(
  parameter int MAX_COLUMNS = trcs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = trcs_pkg::DEF_MAX_ROWS,
  parameter int NUM_LAYERS  = trcs_pkg::DEF_NUM_LAYERS
) (
  input  logic            clk,
  input  logic            rst,
  input  trcs_pkg::cfg_t  cfg,
  input  trcs_pkg::item_t q_head,
  input  logic            q_empty,
  output logic            pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            hit,
  output logic [5:0]      hit_row,
  output logic [5:0]      hit_column
);

  localparam int DEPTH = NUM_LAYERS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_ROW, B_COL, B_OUT} bstate_t;

  bstate_t state;
  trcs_pkg::item_t ent;
  logic [MAX_COLUMNS-1:0] mem [DEPTH];
  logic [MAX_COLUMNS-1:0] rdata;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [trcs_pkg::DIM_W-1:0] r;
  logic [trcs_pkg::DIM_W-1:0] c;
  logic [trcs_pkg::SCAN_W-1:0] k;
  logic [trcs_pkg::SCAN_W-1:0] scan;
  logic signed [trcs_pkg::COORD_W-1:0] ty;
  logic signed [trcs_pkg::COORD_W-1:0] tx;
  logic signed [trcs_pkg::COORD_W-1:0] tsq_s;
  logic found;
  logic last_row;
  logic row_hit;
  logic col_on;
  logic col_hit;
  logic do_write;

  assign clearing = (state == B_CLEAR);
  assign pop      = (state == B_IDLE) && !q_empty;
  assign do_write = pop && !q_head.query && !q_head.reject;
  assign tsq_s    = $signed(trcs_pkg::COORD_W'(cfg.tsq));
  assign scan     = (cfg.scan == '0) ? trcs_pkg::SCAN_W'(1) : cfg.scan;
  assign raddr    = AW'(32'(ent.layer) * MAX_ROWS + 32'(r));
  assign waddr    = AW'(32'(q_head.layer) * MAX_ROWS + 32'(q_head.wrow));
  assign last_row = (r == cfg.rows - trcs_pkg::DIM_W'(1));
  assign row_hit  = (ent.top < ty + tsq_s) && (ent.bottom > ty);
  assign col_on   = (c < cfg.cols) && (k < scan);
  assign col_hit  = rdata[c[CIW-1:0]] && (ent.left < tx + tsq_s) && (ent.right > tx);

  always_ff @(posedge clk) begin
    if (state == B_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (do_write) begin
      mem[waddr][CIW'(q_head.wcol)] <= q_head.wsolid;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != B_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            ent   <= q_head;
            found <= 1'b0;
            r     <= '0;
            ty    <= '0;
            state <= (!q_head.query || q_head.reject) ? B_OUT : B_ROW;
          end
        end
        B_ROW: begin
          if (row_hit) begin
            c     <= ent.cmin;
            k     <= '0;
            tx    <= ent.tx0;
            state <= B_COL;
          end else if (last_row) begin
            state <= B_OUT;
          end else begin
            r  <= r + trcs_pkg::DIM_W'(1);
            ty <= ty + tsq_s;
          end
        end
        B_COL: begin
          if (col_on) begin
            if (col_hit) begin
              found <= 1'b1;
              state <= B_OUT;
            end else begin
              c  <= c + trcs_pkg::DIM_W'(1);
              k  <= k + trcs_pkg::SCAN_W'(1);
              tx <= tx + tsq_s;
            end
          end else if (last_row) begin
            state <= B_OUT;
          end else begin
            r     <= r + trcs_pkg::DIM_W'(1);
            ty    <= ty + tsq_s;
            state <= B_ROW;
          end
        end
        B_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            hit        <= found;
            hit_row    <= found ? 6'(r) : 6'd0;
            hit_column <= found ? 6'(c) : 6'd0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/tilemap_rect_collision_scan_unit.sv =====
// top level of the tile map rectangle collision scan unit
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | in_valid / in_stall        | operation layer tile_row tile_column
//          |                            | tile_solid rect_left rect_top rect_width
//          |                            | rect_height
//  out     | out_valid / out_stall      | hit hit_row hit_column
//  cfg     | cfg_write                  | cfg_index cfg_data
//
// a write item goes from idle straight to the front's push state and its result
// is registered in the back's B_OUT state; a query steps the front through F_MUL,
// F_CHECK, F_DIV (a serial divider for the start column) and F_TX, these two
// skipped when rejected or rect_left is not positive, then F_PUSH; unless rejected
// the back tests rows in B_ROW and scans the columns of each overlapping row in
// B_COL, one tile memory row read per row; the front works on the next item while
// the back scans; after reset the tile memory is cleared one row per cycle, all
// NUM_LAYERS*MAX_ROWS rows, while in_stall stays high; a stalled result holds in
// the output register and the front goes on until the two-entry queue fills
module tilemap_rect_collision_scan_unit #(
  parameter int MAX_COLUMNS = trcs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = trcs_pkg::DEF_MAX_ROWS,
  parameter int NUM_LAYERS  = trcs_pkg::DEF_NUM_LAYERS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [1:0]                         layer,
  input  logic [5:0]                         tile_row,
  input  logic [5:0]                         tile_column,
  input  logic                               tile_solid,
  input  logic signed [15:0]                 rect_left,
  input  logic signed [15:0]                 rect_top,
  input  logic [14:0]                        rect_width,
  input  logic [14:0]                        rect_height,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic [5:0]                         hit_row,
  output logic [5:0]                         hit_column,
  input  logic                               cfg_write,
  input  logic [trcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [6:0] map_columns;
  logic [6:0] map_rows;
  logic [8:0] tile_size;
  logic [6:0] scan_columns;
  logic [3:0] layer_present;
  logic [8:0] ts;
  trcs_pkg::cfg_t  cfg;
  trcs_pkg::item_t f_ent;
  trcs_pkg::item_t q_head;
  logic front_busy;
  logic clearing;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns   <= 7'd64;
      map_rows      <= 7'd64;
      tile_size     <= 9'd16;
      scan_columns  <= 7'd23;
      layer_present <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        trcs_pkg::REG_MAP_COLUMNS:   map_columns   <= cfg_data[6:0];
        trcs_pkg::REG_MAP_ROWS:      map_rows      <= cfg_data[6:0];
        trcs_pkg::REG_TILE_SIZE:     tile_size     <= cfg_data;
        trcs_pkg::REG_SCAN_COLUMNS:  scan_columns  <= cfg_data[6:0];
        trcs_pkg::REG_LAYER_PRESENT: layer_present <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_columns == 7'd0) begin
      cfg.cols = trcs_pkg::DIM_W'(1);
    end else if (trcs_pkg::DIM_W'(map_columns) > trcs_pkg::DIM_W'(MAX_COLUMNS)) begin
      cfg.cols = trcs_pkg::DIM_W'(MAX_COLUMNS);
    end else begin
      cfg.cols = trcs_pkg::DIM_W'(map_columns);
    end
    if (map_rows == 7'd0) begin
      cfg.rows = trcs_pkg::DIM_W'(1);
    end else if (trcs_pkg::DIM_W'(map_rows) > trcs_pkg::DIM_W'(MAX_ROWS)) begin
      cfg.rows = trcs_pkg::DIM_W'(MAX_ROWS);
    end else begin
      cfg.rows = trcs_pkg::DIM_W'(map_rows);
    end
    if (tile_size == 9'd0) begin
      ts = 9'd1;
    end else if (tile_size > 9'd256) begin
      ts = 9'd256;
    end else begin
      ts = tile_size;
    end
    cfg.tsq  = {ts, 4'b0000};
    cfg.scan = scan_columns;
  end

  assign in_stall = front_busy || clearing;

  trcs_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS),
    .NUM_LAYERS(NUM_LAYERS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(in_valid && !in_stall),
    .operation(operation),
    .layer(layer),
    .tile_row(tile_row),
    .tile_column(tile_column),
    .tile_solid(tile_solid),
    .rect_left(rect_left),
    .rect_top(rect_top),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .cfg(cfg),
    .layer_present(layer_present),
    .busy(front_busy),
    .push(push),
    .q_full(q_full),
    .ent(f_ent)
  );

  trcs_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(f_ent),
    .pop(pop),
    .dout(q_head),
    .full(q_full),
    .empty(q_empty)
  );

  trcs_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS),
    .NUM_LAYERS(NUM_LAYERS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_head(q_head),
    .q_empty(q_empty),
    .pop(pop),
    .clearing(clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .hit_row(hit_row),
    .hit_column(hit_column)
  );

endmodule

// ===== hdl/trcs_checker.sv =====
// port checker for the collision scan unit and its bind
module trcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       hit,
  input logic [5:0] hit_row,
  input logic [5:0] hit_column
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_row) &&
                               $stable(hit_column))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_row == 6'd0 && hit_column == 6'd0)
    else $error("miss with nonzero position");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_clear_stall: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall)
    else $error("item taken during clearing pass");

endmodule

bind tilemap_rect_collision_scan_unit trcs_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .hit(hit),
  .hit_row(hit_row),
  .hit_column(hit_column)
);
